[hdl/cccv_charge_regulator_defines.svh]
// Assertion macros for the CC/CV charge regulator.
// Used by the top level; needs nothing else.
`ifndef CCCV_CHARGE_REGULATOR_DEFINES_SVH
`define CCCV_CHARGE_REGULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCCV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCCV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cccv_pkg.sv]
// Shared types and constants for the CC/CV charge regulator.
// No dependencies; every other HDL file but the defines header uses it.
`default_nettype none

package cccv_pkg;

  localparam int DATA_W = 10;  // ADC sample, duty and register width
  localparam int SUM_W  = 13;  // current accumulator width
  localparam int CNT_W  = 3;   // sample counter width
  localparam int IDX_W  = 2;   // configuration register index width

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_TARGET_VOLTAGE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TARGET_CURRENT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_LITHIUM_CUTOFF = 2'd2;
  localparam logic [IDX_W-1:0] CFG_NICKEL_CUTOFF  = 2'd3;

  // Reset values of the end-of-charge thresholds.
  localparam logic [DATA_W-1:0] LITHIUM_CUTOFF_RST = 10'd55;
  localparam logic [DATA_W-1:0] NICKEL_CUTOFF_RST  = 10'd25;

  typedef enum logic [1:0] {
    ACT_REGULATE = 2'd0,
    ACT_EOC      = 2'd1,
    ACT_START    = 2'd2,
    ACT_STOP     = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] battery_voltage;
    logic [DATA_W-1:0] measured_current;
    logic              is_lithium;
    logic              disconnected;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] pwm_duty;
    logic              regulator_on;
    logic              charge_done;
    logic              constant_current;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] target_voltage;
    logic [DATA_W-1:0] target_current;
    logic [DATA_W-1:0] lithium_cutoff;
    logic [DATA_W-1:0] nickel_cutoff;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/cccv_cfg_regs.sv]
// Configuration register file of the CC/CV charge regulator.
// Depends on cccv_pkg for the index codes and the cfg_t bundle.
`default_nettype none

module cccv_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cccv_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [cccv_pkg::DATA_W-1:0]  cfg_data_i,
  output cccv_pkg::cfg_t                    cfg_o
);

  cccv_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cccv_pkg::CFG_TARGET_VOLTAGE: cfg_d.target_voltage = cfg_data_i;
        cccv_pkg::CFG_TARGET_CURRENT: cfg_d.target_current = cfg_data_i;
        cccv_pkg::CFG_LITHIUM_CUTOFF: cfg_d.lithium_cutoff = cfg_data_i;
        cccv_pkg::CFG_NICKEL_CUTOFF:  cfg_d.nickel_cutoff  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_voltage <= '0;
      cfg_q.target_current <= '0;
      cfg_q.lithium_cutoff <= cccv_pkg::LITHIUM_CUTOFF_RST;
      cfg_q.nickel_cutoff  <= cccv_pkg::NICKEL_CUTOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/cccv_ctrl.sv]
// Regulation state and next-state logic of the CC/CV charge regulator.
// Depends on cccv_pkg; the result word shows the state after the item.
`default_nettype none

module cccv_ctrl #(
  parameter int AVERAGE_SAMPLES = 5,
  parameter int DUTY_LIMIT      = 1022
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,   // commit the state for the word below
  input  wire cccv_pkg::in_t item_i,
  input  wire cccv_pkg::cfg_t cfg_i,
  output cccv_pkg::out_t result_o
);

  localparam int DataW = cccv_pkg::DATA_W;
  localparam int SumW  = cccv_pkg::SUM_W;
  localparam int CntW  = cccv_pkg::CNT_W;

  localparam logic [DataW-1:0] Limit     = DataW'(DUTY_LIMIT);
  localparam logic [DataW-1:0] LimitLess = DataW'(DUTY_LIMIT - 1);
  localparam logic [CntW-1:0]  Samples   = CntW'(AVERAGE_SAMPLES);

  logic             enable_q, enable_d;
  logic             done_q, done_d;
  logic [DataW-1:0] duty_q, duty_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             ramp_up, ramp_down;
  logic [DataW-1:0] cutoff;
  logic [SumW-1:0]  threshold;

  assign ramp_up   = (item_i.battery_voltage < cfg_i.target_voltage) &&
                     (item_i.measured_current < cfg_i.target_current);
  assign ramp_down = (item_i.battery_voltage > cfg_i.target_voltage) ||
                     (item_i.measured_current > cfg_i.target_current);

  // floor(sum / N) < cutoff holds exactly when sum < cutoff * N.
  assign cutoff    = item_i.is_lithium ? cfg_i.lithium_cutoff : cfg_i.nickel_cutoff;
  assign threshold = SumW'(cutoff) * SumW'(AVERAGE_SAMPLES);

  always_comb begin
    enable_d = enable_q;
    done_d   = done_q;
    duty_d   = duty_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    case (item_i.action)
      cccv_pkg::ACT_REGULATE: begin
        if (enable_q) begin
          if (ramp_up) begin
            duty_d = (duty_q < LimitLess) ? duty_q + DataW'(1) : Limit;
          end else if (ramp_down) begin
            duty_d = (duty_q > DataW'(1)) ? duty_q - DataW'(1) : '0;
          end
        end
      end
      cccv_pkg::ACT_EOC: begin
        if (cnt_q < Samples) begin
          sum_d = sum_q + SumW'(item_i.measured_current);
          cnt_d = cnt_q + CntW'(1);
        end else begin
          if (sum_q < threshold) begin
            done_d = 1'b1;
            if (item_i.is_lithium || item_i.disconnected) begin
              duty_d   = '0;
              enable_d = 1'b0;
            end
          end
          sum_d = '0;
          cnt_d = '0;
        end
      end
      cccv_pkg::ACT_START: begin
        done_d   = 1'b0;
        duty_d   = '0;
        enable_d = 1'b1;
      end
      cccv_pkg::ACT_STOP: begin
        duty_d   = '0;
        enable_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      done_q   <= 1'b1;
      duty_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else if (step_i) begin
      enable_q <= enable_d;
      done_q   <= done_d;
      duty_q   <= duty_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
    end
  end

  assign result_o.pwm_duty         = duty_d;
  assign result_o.regulator_on     = enable_d;
  assign result_o.charge_done      = done_d;
  assign result_o.constant_current = item_i.measured_current < cfg_i.target_current;

endmodule

`default_nettype wire

[hdl/cccv_charge_regulator.sv]
// Top level of the CC/CV charge regulator: input register, result register.
// Depends on cccv_pkg, cccv_cfg_regs, cccv_ctrl and the defines header.
//
// Usage:
// Input words arrive on in_valid_i/in_ready_o/in_data_i; each word carries an
// action (regulate tick, end-of-charge tick, start, stop) and the ADC samples.
// Every accepted word yields exactly one result word on out_valid_o/
// out_ready_i/out_data_o, which shows the duty, enable and done state after
// that word, plus a flag telling whether the current is below its target.
// An accepted word sits in the input register, and its result is loaded
// into the result register at the edge where that word advances. One word
// per cycle is sustained while the receiver does not stall; the next word
// only needs the state committed by the previous one when its result loads.
// When the receiver stalls, the result register holds its word, the input
// register still takes one more word, and in_ready_o drops only when both
// registers are full. Reset clears both valid flags and the regulator state:
// regulator off, duty zero, done set, averaging window empty; the cutoff
// registers return to 55 (lithium) and 25 (NiMH). The configuration port
// writes one register per cycle with cfg_we_i high and should be used only
// while no word is in flight.
`default_nettype none

`include "cccv_charge_regulator_defines.svh"

module cccv_charge_regulator #(
  parameter int AVERAGE_SAMPLES = 5,
  parameter int DUTY_LIMIT      = 1022
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire cccv_pkg::in_t                in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output cccv_pkg::out_t                    out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [cccv_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [cccv_pkg::DATA_W-1:0]  cfg_data_i
);

  cccv_pkg::cfg_t cfg;
  cccv_pkg::in_t  item_q;
  cccv_pkg::out_t result;
  cccv_pkg::out_t out_q;

  logic item_valid_q, item_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_fire, advance;

  // The item in the input register moves on whenever the result register is
  // free or being emptied in this cycle; the state commits at the same edge.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign item_valid_d = in_fire || (item_valid_q && !advance);
  assign out_valid_d  = advance || (out_valid_q && !out_ready_i);

  cccv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cccv_ctrl #(
    .AVERAGE_SAMPLES (AVERAGE_SAMPLES),
    .DUTY_LIMIT      (DUTY_LIMIT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A word that leaves the input register always lands in the result register.
  `CCCV_ASSERT_NXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q, "result word lost")
  // The regulator never reports a nonzero duty while it is off.
  `CCCV_ASSERT_IMP(a_off_means_zero_duty, clk_i, rst_ni, out_valid_q && !out_q.regulator_on, out_q.pwm_duty == '0, "duty nonzero while off")
  // The duty never rises above its limit.
  `CCCV_ASSERT_IMP(a_duty_limit, clk_i, rst_ni, out_valid_q, out_q.pwm_duty <= cccv_pkg::DATA_W'(DUTY_LIMIT), "duty above limit")

endmodule

`default_nettype wire

[tb/cccv_charge_regulator_tb.sv]
// Self-checking testbench for the CC/CV charge regulator: directed and random words
// checked against a cycle-free model of the duty, enable and end-of-charge state.
// Depends on cccv_pkg and the cccv_charge_regulator top level only.
module cccv_charge_regulator_tb;

  // These must match the parameters the block is built with below.
  localparam int AVERAGE_SAMPLES = 5;
  localparam int DUTY_LIMIT      = 1022;

  localparam int DATA_W = cccv_pkg::DATA_W;
  localparam int SUM_W  = cccv_pkg::SUM_W;
  localparam int CNT_W  = cccv_pkg::CNT_W;
  localparam int IDX_W  = cccv_pkg::IDX_W;

  // In a correct run the gaps without a handshake (idle bursts, stalls,
  // configuration writes) stay well below this limit.
  localparam int WATCHDOG_LIMIT  = 500;
  localparam int SETTLE_CYCLES   = 10;
  localparam int PHASE_WORDS     = 60;
  localparam int RAMP_WORDS      = 60;

  // Model of the regulator. It keeps its own copy of the registers and of the
  // regulator state, predicts one result word per accepted input word, and
  // compares arriving results against the oldest prediction.
  class charge_scoreboard;
    cccv_pkg::cfg_t    regs;
    logic              running;
    logic              finished;
    logic [DATA_W-1:0] duty;
    logic [SUM_W-1:0]  amp_sum;
    logic [CNT_W-1:0]  amp_count;
    cccv_pkg::out_t    awaited[$];
    int                mismatches;
    int                words;
    int                results;
    int                detections;
    int                duty_at_limit;
    int                per_action[4];

    function new();
      regs.target_voltage = '0;
      regs.target_current = '0;
      regs.lithium_cutoff = cccv_pkg::LITHIUM_CUTOFF_RST;
      regs.nickel_cutoff  = cccv_pkg::NICKEL_CUTOFF_RST;
      running       = 1'b0;
      finished      = 1'b1;
      duty          = '0;
      amp_sum       = '0;
      amp_count     = '0;
      mismatches    = 0;
      words         = 0;
      results       = 0;
      detections    = 0;
      duty_at_limit = 0;
      for (int k = 0; k < 4; k++) per_action[k] = 0;
    endfunction

    function void complain(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Advance the model by one accepted input word and queue its result.
    function void note_word(input cccv_pkg::in_t w);
      cccv_pkg::out_t    want;
      logic [SUM_W-1:0]  mean;
      logic [DATA_W-1:0] cutoff;
      words++;
      per_action[w.action]++;
      case (w.action)
        cccv_pkg::ACT_REGULATE: if (running) begin
          if (w.battery_voltage < regs.target_voltage &&
              w.measured_current < regs.target_current) begin
            if (duty < DUTY_LIMIT - 1) duty = duty + 1'b1;
            else duty = DATA_W'(DUTY_LIMIT);
          end else if (w.battery_voltage > regs.target_voltage ||
                       w.measured_current > regs.target_current) begin
            if (duty > 1) duty = duty - 1'b1;
            else duty = '0;
          end
        end
        cccv_pkg::ACT_EOC: begin
          if (amp_count < AVERAGE_SAMPLES) begin
            amp_sum   = amp_sum + SUM_W'(w.measured_current);
            amp_count = amp_count + 1'b1;
          end else begin
            // The evaluating tick drops its own sample.
            mean   = amp_sum / AVERAGE_SAMPLES;
            cutoff = w.is_lithium ? regs.lithium_cutoff : regs.nickel_cutoff;
            if (mean < cutoff) begin
              finished = 1'b1;
              detections++;
              if (w.is_lithium || w.disconnected) begin
                duty    = '0;
                running = 1'b0;
              end
            end
            amp_sum   = '0;
            amp_count = '0;
          end
        end
        cccv_pkg::ACT_START: begin
          finished = 1'b0;
          duty     = '0;
          running  = 1'b1;
        end
        default: begin
          duty    = '0;
          running = 1'b0;
        end
      endcase
      if (duty == DUTY_LIMIT) duty_at_limit++;
      want.pwm_duty         = duty;
      want.regulator_on     = running;
      want.charge_done      = finished;
      want.constant_current = w.measured_current < regs.target_current;
      awaited.push_back(want);
    endfunction

    function void check_result(input cccv_pkg::out_t got);
      cccv_pkg::out_t want;
      results++;
      if (awaited.size() == 0) begin
        complain($sformatf("result word %h arrived with none awaited", got));
        return;
      end
      want = awaited.pop_front();
      if (got.pwm_duty !== want.pwm_duty)
        complain($sformatf("pwm_duty expected %0d, got %0d", want.pwm_duty, got.pwm_duty));
      if (got.regulator_on !== want.regulator_on)
        complain($sformatf("regulator_on expected %b, got %b",
                           want.regulator_on, got.regulator_on));
      if (got.charge_done !== want.charge_done)
        complain($sformatf("charge_done expected %b, got %b",
                           want.charge_done, got.charge_done));
      if (got.constant_current !== want.constant_current)
        complain($sformatf("constant_current expected %b, got %b",
                           want.constant_current, got.constant_current));
    endfunction

    function bit clean();
      if (awaited.size() != 0)
        complain($sformatf("%0d result words never arrived", awaited.size()));
      return mismatches == 0;
    endfunction

    function void summary();
      $display("Run covered %0d words (%0d regulate, %0d end-of-charge, %0d start, %0d stop);",
               words, per_action[cccv_pkg::ACT_REGULATE], per_action[cccv_pkg::ACT_EOC],
               per_action[cccv_pkg::ACT_START], per_action[cccv_pkg::ACT_STOP]);
      $display("%0d results checked, %0d end-of-charge detections, duty at its limit %0d times.",
               results, detections, duty_at_limit);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  cccv_pkg::in_t     in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  cccv_pkg::out_t    out_data_o;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_index_i;
  logic [DATA_W-1:0] cfg_data_i;

  charge_scoreboard board;
  // When clear, neither the sender nor the receiver inserts idle cycles.
  bit idle_on = 1'b1;

  cccv_charge_regulator #(
    .AVERAGE_SAMPLES(AVERAGE_SAMPLES),
    .DUTY_LIMIT     (DUTY_LIMIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: ready is high except during random stall bursts. A burst sets
  // out_ready_i low at its start and high again at its end, not at every edge.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Result monitor. Outputs are sampled at the edge, before the registers
  // update, so the values seen are those the block presented at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // Watchdog: a correct block never goes long without some handshake.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[%0t] Watchdog: no word moved for %0d cycles", $time, quiet);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic cccv_pkg::in_t make_word(input cccv_pkg::action_e act,
                                              input logic [DATA_W-1:0] volts,
                                              input logic [DATA_W-1:0] amps,
                                              input logic lithium, input logic gone);
    cccv_pkg::in_t w;
    w.action           = act;
    w.battery_voltage  = volts;
    w.measured_current = amps;
    w.is_lithium       = lithium;
    w.disconnected     = gone;
    return w;
  endfunction

  // Samples cluster around a threshold so that the equal, just-below and
  // just-above cases come up often; the rest spans the full range.
  function automatic logic [DATA_W-1:0] near(input logic [DATA_W-1:0] anchor);
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 7))
      0: r = (anchor == '0) ? anchor : anchor - 1'b1;
      1: r = anchor;
      2: r = (anchor == '1) ? anchor : anchor + 1'b1;
      3: r = '0;
      4: r = '1;
      5: r = anchor >> 1;
      default: r = DATA_W'($urandom_range(0, 1023));
    endcase
    return r;
  endfunction

  // Mostly regulate and end-of-charge ticks inside a charging session, with
  // occasional start and stop words breaking into it.
  function automatic cccv_pkg::in_t rand_word();
    cccv_pkg::in_t w;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) w.action = cccv_pkg::ACT_START;
    else if (pick < 11) w.action = cccv_pkg::ACT_STOP;
    else if (pick < 46) w.action = cccv_pkg::ACT_EOC;
    else w.action = cccv_pkg::ACT_REGULATE;
    w.is_lithium      = 1'($urandom_range(0, 1));
    w.disconnected    = ($urandom_range(0, 3) == 0);
    w.battery_voltage = near(board.regs.target_voltage);
    if (w.action == cccv_pkg::ACT_EOC)
      w.measured_current = near(w.is_lithium ? board.regs.lithium_cutoff
                                             : board.regs.nickel_cutoff);
    else
      w.measured_current = near(board.regs.target_current);
    return w;
  endfunction

  function automatic cccv_pkg::cfg_t rand_settings();
    cccv_pkg::cfg_t c;
    c.target_voltage = DATA_W'($urandom_range(0, 1023));
    c.target_current = DATA_W'($urandom_range(0, 1023));
    c.lithium_cutoff = DATA_W'($urandom_range(0, 1023));
    c.nickel_cutoff  = DATA_W'($urandom_range(0, 1023));
    return c;
  endfunction

  // Sends one word and returns at the edge where it was accepted. Valid is
  // left high so that a following call can present the next word at once;
  // stop_sending() lowers it when no word follows.
  task automatic send_word(input cccv_pkg::in_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(w);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  // Holds the sender off until every predicted result has been checked.
  task automatic drain();
    stop_sending();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Writes all four registers, one per cycle. Only called with nothing in
  // flight, so the model may take the new values at once.
  task automatic load_settings(input cccv_pkg::cfg_t c);
    logic [IDX_W-1:0]  idx[4];
    logic [DATA_W-1:0] val[4];
    idx[0] = cccv_pkg::CFG_TARGET_VOLTAGE;  val[0] = c.target_voltage;
    idx[1] = cccv_pkg::CFG_TARGET_CURRENT;  val[1] = c.target_current;
    idx[2] = cccv_pkg::CFG_LITHIUM_CUTOFF;  val[2] = c.lithium_cutoff;
    idx[3] = cccv_pkg::CFG_NICKEL_CUTOFF;   val[3] = c.nickel_cutoff;
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    board.regs = c;
  endtask

  // One random phase: new settings, a start word, then random words. With
  // pause_mid set, the sender stops halfway until all results are back.
  task automatic run_phase(input cccv_pkg::cfg_t c, input bit pause_mid);
    drain();
    load_settings(c);
    send_word(make_word(cccv_pkg::ACT_START, near(c.target_voltage),
                        near(c.target_current), 1'b0, 1'b0));
    for (int k = 0; k < PHASE_WORDS; k++) begin
      if (pause_mid && k == PHASE_WORDS / 2) drain();
      send_word(rand_word());
    end
    stop_sending();
  endtask

  initial begin
    cccv_pkg::cfg_t c;
    board = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= cccv_pkg::CFG_TARGET_VOLTAGE;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the regulator is off, so a regulate tick changes nothing
    // and the result shows the reset state.
    send_word(make_word(cccv_pkg::ACT_REGULATE, '0, '0, 1'b0, 1'b0));
    drain();

    c.target_voltage = 10'd600;
    c.target_current = 10'd400;
    c.lithium_cutoff = cccv_pkg::LITHIUM_CUTOFF_RST;
    c.nickel_cutoff  = cccv_pkg::NICKEL_CUTOFF_RST;
    load_settings(c);

    // Ramp up, hold at equality, step down and saturate at zero.
    send_word(make_word(cccv_pkg::ACT_START,    10'd1023, 10'd1023, 1'b1, 1'b1));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd100,  10'd100,  1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd599,  10'd399,  1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd600,  10'd399,  1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd600,  10'd400,  1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd601,  10'd0,    1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd0,    10'd401,  1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd1023, 10'd1023, 1'b0, 1'b0));

    // Stop keeps done low; end-of-charge sampling still runs while the
    // regulator is off, and a low lithium mean sets done.
    send_word(make_word(cccv_pkg::ACT_STOP, 10'd0, 10'd0, 1'b0, 1'b0));
    for (int k = 0; k < AVERAGE_SAMPLES; k++)
      send_word(make_word(cccv_pkg::ACT_EOC, 10'd0, 10'd10, 1'b1, 1'b0));
    send_word(make_word(cccv_pkg::ACT_EOC, 10'd0, 10'd1023, 1'b1, 1'b0));

    // NiMH, still connected: done is set but the regulator keeps running.
    send_word(make_word(cccv_pkg::ACT_START,    10'd0, 10'd0, 1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd0, 10'd0, 1'b0, 1'b0));
    for (int k = 0; k < AVERAGE_SAMPLES; k++)
      send_word(make_word(cccv_pkg::ACT_EOC, 10'd0, 10'd20, 1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_EOC, 10'd0, 10'd0, 1'b0, 1'b0));

    // NiMH but disconnected: a detection halts the regulator.
    send_word(make_word(cccv_pkg::ACT_START, 10'd0, 10'd0, 1'b0, 1'b0));
    for (int k = 0; k < AVERAGE_SAMPLES; k++)
      send_word(make_word(cccv_pkg::ACT_EOC, 10'd0, 10'd24, 1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_EOC, 10'd0, 10'd0, 1'b0, 1'b1));

    // With both targets at full scale every regulate tick below full scale
    // raises the duty; afterwards a full-scale voltage and a full-scale current
    // each leave it unchanged.
    drain();
    c.target_voltage = '1;
    c.target_current = '1;
    load_settings(c);
    send_word(make_word(cccv_pkg::ACT_START, 10'd0, 10'd0, 1'b0, 1'b0));
    for (int k = 0; k < RAMP_WORDS; k++)
      send_word(make_word(cccv_pkg::ACT_REGULATE, DATA_W'($urandom_range(0, 1022)),
                          DATA_W'($urandom_range(0, 1022)), 1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd1023, 10'd0, 1'b0, 1'b0));
    send_word(make_word(cccv_pkg::ACT_REGULATE, 10'd0, 10'd1023, 1'b0, 1'b0));
    stop_sending();

    // Random phases: all-zero and all-full settings, a mid-range one with a
    // pause in the middle, then random settings; the last has no idling.
    c = '0;
    run_phase(c, 1'b0);
    c = '1;
    run_phase(c, 1'b0);
    c.target_voltage = 10'd512;
    c.target_current = 10'd300;
    c.lithium_cutoff = cccv_pkg::LITHIUM_CUTOFF_RST;
    c.nickel_cutoff  = cccv_pkg::NICKEL_CUTOFF_RST;
    run_phase(c, 1'b1);
    run_phase(rand_settings(), 1'b0);
    run_phase(rand_settings(), 1'b0);
    drain();
    idle_on = 1'b0;
    run_phase(rand_settings(), 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    board.summary();
    if (board.clean()) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[cccv_charge_regulator.f]
+incdir+hdl
hdl/cccv_pkg.sv
hdl/cccv_cfg_regs.sv
hdl/cccv_ctrl.sv
hdl/cccv_charge_regulator.sv
tb/cccv_charge_regulator_tb.sv
